@@ src/assert_macros.svh @@
// Concurrent assertion helpers, clocked on clk_i, off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define RGBBMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGBBMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rgbbmp_pkg.sv @@
package rgbbmp_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;
  localparam int unsigned ROW_W   = DIM_W + 2;      // 3*w + pad
  localparam int unsigned IMG_W   = ROW_W + DIM_W;  // row bytes * h
  localparam int unsigned IDX_W   = 6;

  localparam logic [11:0] RST_WIDTH  = 12'd32;
  localparam logic [11:0] RST_HEIGHT = 12'd24;

  localparam logic [IDX_W-1:0] HDR_BYTES = 6'd54;
  localparam logic [31:0] DIB_SIZE  = 32'd40;
  localparam logic [31:0] PLANES    = 32'd1;
  localparam logic [31:0] BPP       = 32'd24;
  localparam logic [31:0] PPM       = 32'd2835;
  localparam logic [31:0] MAGIC_BM  = 32'h0000_4D42;

  // header field offsets
  localparam logic [IDX_W-1:0] OFS_MAGIC = 6'd0;
  localparam logic [IDX_W-1:0] OFS_FSIZE = 6'd2;
  localparam logic [IDX_W-1:0] OFS_DATA  = 6'd10;
  localparam logic [IDX_W-1:0] OFS_DIB   = 6'd14;
  localparam logic [IDX_W-1:0] OFS_WIDTH = 6'd18;
  localparam logic [IDX_W-1:0] OFS_HGT   = 6'd22;
  localparam logic [IDX_W-1:0] OFS_PLN   = 6'd26;
  localparam logic [IDX_W-1:0] OFS_BPP   = 6'd28;
  localparam logic [IDX_W-1:0] OFS_ISIZE = 6'd34;
  localparam logic [IDX_W-1:0] OFS_XRES  = 6'd38;
  localparam logic [IDX_W-1:0] OFS_YRES  = 6'd42;

  // floor(v*255/31) and floor(v*255/63) as v * (255 * ceil(2^20/d)) >> 20
  localparam logic [28:0] EXP5_MUL = 29'd8625630;
  localparam logic [28:0] EXP6_MUL = 29'd4244475;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  function automatic logic [7:0] exp5(logic [4:0] v);
    logic [28:0] p;
    p = 29'(v) * EXP5_MUL;
    return p[27:20];
  endfunction

  function automatic logic [7:0] exp6(logic [5:0] v);
    logic [28:0] p;
    p = 29'(v) * EXP6_MUL;
    return p[27:20];
  endfunction

  function automatic logic [7:0] hdr_byte(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] w,
                                          logic [DIM_W-1:0] h, logic [IMG_W-1:0] img);
    logic [31:0]      fld;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] ofs;
    logic [31:0]      fsize;
    fsize = 32'(img) + 32'(HDR_BYTES);
    fld   = '0;
    base  = idx;
    case (idx) inside
      [OFS_MAGIC : OFS_MAGIC + 6'd1]: begin fld = MAGIC_BM;      base = OFS_MAGIC; end
      [OFS_FSIZE : OFS_FSIZE + 6'd3]: begin fld = fsize;         base = OFS_FSIZE; end
      [OFS_DATA  : OFS_DATA  + 6'd3]: begin fld = 32'(HDR_BYTES); base = OFS_DATA; end
      [OFS_DIB   : OFS_DIB   + 6'd3]: begin fld = DIB_SIZE;      base = OFS_DIB;   end
      [OFS_WIDTH : OFS_WIDTH + 6'd3]: begin fld = 32'(w);        base = OFS_WIDTH; end
      [OFS_HGT   : OFS_HGT   + 6'd3]: begin fld = 32'(h);        base = OFS_HGT;   end
      [OFS_PLN   : OFS_PLN   + 6'd1]: begin fld = PLANES;        base = OFS_PLN;   end
      [OFS_BPP   : OFS_BPP   + 6'd1]: begin fld = BPP;           base = OFS_BPP;   end
      [OFS_ISIZE : OFS_ISIZE + 6'd3]: begin fld = 32'(img);      base = OFS_ISIZE; end
      [OFS_XRES  : OFS_XRES  + 6'd3]: begin fld = PPM;           base = OFS_XRES;  end
      [OFS_YRES  : OFS_YRES  + 6'd3]: begin fld = PPM;           base = OFS_YRES;  end
      default: begin fld = '0; base = idx; end
    endcase
    ofs = idx - base;
    return 8'(fld >> {ofs[1:0], 3'b000});
  endfunction

endpackage

@@ src/rgbbmp_pix_if.sv @@
interface rgbbmp_pix_if import rgbbmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_rgb565;

  modport source (output valid, output pixel_rgb565, input ready);
  modport sink   (input valid, input pixel_rgb565, output ready);
endinterface

@@ src/rgbbmp_byte_if.sv @@
interface rgbbmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       frame_done;

  modport source (output valid, output out_byte, output last_of_run, output frame_done,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input frame_done,
                  output ready);
endinterface

@@ src/rgbbmp_cfg_if.sv @@
interface rgbbmp_cfg_if import rgbbmp_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_reg_e         index;
  logic [DIM_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/rgb565_to_bmp24_stream_encoder.sv @@
// RGB565 pixel stream in, 24-bit BMP file byte stream out.
// pix_i   : one RGB565 pixel per transaction, rows bottom row first, left to right.
// bytes_o : one file byte per transaction; last_of_run marks the final byte caused
//           by a pixel, frame_done the final byte of the file.
// cfg_i   : register writes (index 0 width, 1 height); always ready, write only
//           while the stream is idle. 0 reads as 1, large values clamp to the maximum.
// The first pixel of a frame yields the 54-byte header, then B, G, R; the last
// pixel of a row adds 0..3 zero pad bytes.
// An accepted pixel is registered in pix_q and then loaded into the output sequencer.
// Throughput: one byte per cycle from the single output sequencer while bytes_o.ready
// is high; a pixel gives 3 bytes (plus 54 for the header and up to 3 for padding); a
// pixel held in the input register is loaded on the same edge that takes the previous
// pixel's last byte, so there is no gap between pixels.
// Reset: width 32, height 24, counters clear, next pixel starts a new file.
// Stall: while bytes_o.ready is low the current byte holds; one further pixel
// is taken into the input register, then pix_i.ready drops.
module rgb565_to_bmp24_stream_encoder import rgbbmp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rgbbmp_pix_if.sink           pix_i,
  rgbbmp_byte_if.source        bytes_o,
  rgbbmp_cfg_if.sink           cfg_i
);

  `include "assert_macros.svh"

  localparam int unsigned MAXW_V = (MAX_WIDTH  > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
  localparam int unsigned MAXH_V = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
  localparam int unsigned COL_W  = $clog2(MAXW_V + 1);
  localparam int unsigned ROW_CW = $clog2(MAXH_V + 1);
  localparam logic [DIM_W-1:0] MAXW_C = DIM_W'(MAXW_V);
  localparam logic [DIM_W-1:0] MAXH_C = DIM_W'(MAXH_V);

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_PIX = 2'd1;
  localparam logic [1:0] PH_PAD = 2'd2;

  localparam logic [IDX_W-1:0] PIX_LAST = 6'd2;

  // configuration, stored already clamped
  logic [DIM_W-1:0] w_q, h_q, cfg_clamp;
  logic [ROW_W-1:0] row_bytes_q;
  logic [IMG_W-1:0] img_q;

  // input register
  logic             pix_vld_q;
  logic [PIX_W-1:0] pix_q;

  // output sequencer
  logic             busy_q;
  logic [1:0]       ph_q, ph_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       pad_q;
  logic             fend_q;
  logic [7:0]       b_q, g_q, r_q;

  // frame position
  logic [COL_W-1:0]  col_q;
  logic [ROW_CW-1:0] row_q;
  logic              hp_q;

  logic             out_take, last, load;
  logic [DIM_W:0]   col_nx, row_nx;
  logic             row_end, frame_end;
  logic [7:0]       byte_mux;

  // config write path
  always_comb begin
    cfg_clamp = cfg_i.data;
    if (cfg_i.index == REG_WIDTH) begin
      if (cfg_i.data == '0) cfg_clamp = DIM_W'(1);
      else if (cfg_i.data > MAXW_C) cfg_clamp = MAXW_C;
    end else begin
      if (cfg_i.data == '0) cfg_clamp = DIM_W'(1);
      else if (cfg_i.data > MAXH_C) cfg_clamp = MAXH_C;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= RST_WIDTH;
      h_q <= RST_HEIGHT;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WIDTH:  w_q <= cfg_clamp;
        REG_HEIGHT: h_q <= cfg_clamp;
        default:    w_q <= w_q;
      endcase
    end
  end

  // image size, two stages behind w_q (row_bytes_q, img_q); img_q takes h_q directly
  always_ff @(posedge clk_i) begin
    row_bytes_q <= ({2'b00, w_q} << 1) + ROW_W'(w_q) + ROW_W'(w_q[1:0]);
    img_q       <= IMG_W'(row_bytes_q) * IMG_W'(h_q);
  end

  // sequencer control
  assign out_take = busy_q && bytes_o.ready;
  assign last     = ((ph_q == PH_PIX) && (idx_q == PIX_LAST) && (pad_q == 2'd0)) ||
                    ((ph_q == PH_PAD) && (idx_q[1:0] == pad_q - 2'd1));
  assign load     = pix_vld_q && (!busy_q || (out_take && last));

  assign pix_i.ready = !pix_vld_q || load;

  assign col_nx    = (DIM_W + 1)'(col_q) + 1'b1;
  assign row_nx    = (DIM_W + 1)'(row_q) + 1'b1;
  assign row_end   = col_nx >= {1'b0, w_q};
  assign frame_end = row_end && (row_nx >= {1'b0, h_q});

  always_comb begin
    ph_d  = ph_q;
    idx_d = idx_q + 1'b1;
    case (ph_q)
      PH_HDR: begin
        if (idx_q == HDR_BYTES - 1'b1) begin
          ph_d  = PH_PIX;
          idx_d = '0;
        end
      end
      PH_PIX: begin
        if (idx_q == PIX_LAST) begin
          ph_d  = PH_PAD;
          idx_d = '0;
        end
      end
      default: ph_d = PH_PAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
      busy_q    <= 1'b0;
      ph_q      <= PH_HDR;
      idx_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      hp_q      <= 1'b1;
    end else begin
      if (pix_i.valid && pix_i.ready) pix_vld_q <= 1'b1;
      else if (load)                  pix_vld_q <= 1'b0;

      if (load) begin
        busy_q <= 1'b1;
        ph_q   <= hp_q ? PH_HDR : PH_PIX;
        idx_q  <= '0;
        hp_q   <= frame_end;
        if (frame_end) begin
          col_q <= '0;
          row_q <= '0;
        end else if (row_end) begin
          col_q <= '0;
          row_q <= ROW_CW'(row_nx);
        end else begin
          col_q <= COL_W'(col_nx);
        end
      end else if (out_take) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          ph_q  <= ph_d;
          idx_q <= idx_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) pix_q <= pix_i.pixel_rgb565;
    if (load) begin
      b_q    <= exp5(pix_q[4:0]);
      g_q    <= exp6(pix_q[10:5]);
      r_q    <= exp5(pix_q[15:11]);
      pad_q  <= row_end ? w_q[1:0] : 2'd0;
      fend_q <= frame_end;
    end
  end

  // output byte select
  always_comb begin
    case (ph_q)
      PH_HDR: byte_mux = hdr_byte(idx_q, w_q, h_q, img_q);
      PH_PIX: begin
        if (idx_q == '0)           byte_mux = b_q;
        else if (idx_q == 6'd1)    byte_mux = g_q;
        else                       byte_mux = r_q;
      end
      default: byte_mux = 8'h00;
    endcase
  end

  assign bytes_o.valid       = busy_q;
  assign bytes_o.out_byte    = byte_mux;
  assign bytes_o.last_of_run = last;
  assign bytes_o.frame_done  = last && fend_q;

  `RGBBMP_ASSERT(a_done_is_last, !(busy_q && fend_q && last) || bytes_o.last_of_run,
                 "frame_done without last_of_run")
  `RGBBMP_ASSERT(a_pad_nonzero, !(busy_q && ph_q == PH_PAD) || (pad_q != 2'd0),
                 "pad phase with zero pad count")
  `RGBBMP_ASSERT_NEXT(a_drain_idle, out_take && last && !pix_vld_q, !busy_q,
                      "sequencer busy after last byte with no pixel held")
  `RGBBMP_ASSERT_NEXT(a_hdr_after_frame, load && frame_end, hp_q && col_q == '0,
                      "header not rearmed at end of frame")

endmodule
